/* hdl/fixed_block_pool_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the fixed block pool allocator
// Implication checks with the clock and active-low reset passed in.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define FBPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fixed_block_pool_allocator: check failed");
// next-cycle implication
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fixed_block_pool_allocator: check failed");
`else
`define FBPA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants, codes and types of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // default number of slots in the pool (2 .. 256)
    localparam int POOL_DEPTH_DEF = 256;
    // word size in bytes; a power of two, slot stride is rounded up to it
    localparam int WORD_BYTES     = 4;

    localparam int CMD_W     = 1;
    localparam int SLOT_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 13;
    localparam int COUNT_W   = 9;
    localparam int STRIDE_W  = SIZE_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int M_DATA_W  = SLOT_W + ADDR_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDRESS = 2'd0,
        REG_BLOCK_BYTES  = 2'd1,
        REG_ITEM_COUNT   = 2'd2
    } reg_index_t;

    localparam logic [SIZE_W-1:0]   BLOCK_BYTES_RST = SIZE_W'(4);
    localparam logic [COUNT_W-1:0]  ITEM_COUNT_RST  = COUNT_W'(256);

endpackage

/* hdl/fbpa_ram.sv */
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/fixed_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool manager with a LIFO free list in a link RAM.
// ----------------------------------------------------------------------------
// Each input beat is a command: allocate (tuser = 0) or free (tuser = 1, slot
// in tdata). Allocate pops the most recently freed slot; with no freed slot it
// hands out never-used slots counting up from zero; with neither it returns
// status "empty". Free pushes a slot below item_count (capped at POOL_DEPTH),
// otherwise it is ignored with status "range". Every command gives exactly one
// result beat with the slot and its byte address, base_address + slot * stride
// (mod 2^32), both zero on an error, stride being the block size raised to one
// word and rounded up to whole words. Freeing a slot twice or freeing a slot
// never handed out is not checked. At accept the read of the link under the
// stack top is issued; in the execute state, once the result register is free
// or draining, the registered link is used and the result register written. A
// new command is taken once the previous result sits in the output register.
// Configuration writes are accepted at any time but are meant for idle.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // command channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fbpa_pkg::SLOT_W-1:0]    s_tdata,   // [7:0] free_slot
    input  logic [fbpa_pkg::CMD_W-1:0]     s_tuser,   // [0] cmd
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fbpa_pkg::M_DATA_W-1:0]  m_tdata,   // [7:0] slot, [39:8] address
    output logic [fbpa_pkg::STATUS_W-1:0]  m_tuser,   // [1:0] status
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::CFG_W-1:0]     cfg_data
);

    import fbpa_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int LW = AW + 1;                 // link: {more_below, slot}
    localparam logic [COUNT_W-1:0] DEPTH_N = COUNT_W'(POOL_DEPTH);
    localparam logic [STRIDE_W-1:0] WORD_MASK = STRIDE_W'(WORD_BYTES - 1);

    typedef enum logic [1:0] {
        STATE_IDLE = 2'b01,
        STATE_EXEC = 2'b10
    } state_t;

    // configuration registers
    logic [ADDR_W-1:0]  base_address_reg;
    logic [SIZE_W-1:0]  block_bytes_reg;
    logic [COUNT_W-1:0] item_count_reg;

    // allocator state
    state_t             state_reg, state_next;
    logic [AW-1:0]      stack_top_reg, stack_top_next;
    logic               stack_nonempty_reg, stack_nonempty_next;
    logic [COUNT_W-1:0] fresh_count_reg, fresh_count_next;

    // captured command
    cmd_t               cmd_reg;
    logic [SLOT_W-1:0]  req_reg;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg, m_tuser_next;

    // link RAM
    logic          link_we;
    logic [AW-1:0] link_waddr;
    logic [LW-1:0] link_wdata;
    logic [LW-1:0] link_rdata;

    logic               in_fire;
    logic               exec_go;
    logic [COUNT_W-1:0] usable_n;
    logic [SIZE_W-1:0]  size_raised;
    logic [STRIDE_W-1:0] stride;
    status_t            status;
    logic [SLOT_W-1:0]  slot_sel;
    logic [21:0]        offset;
    logic [ADDR_W-1:0]  address;

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == STATE_IDLE);
    assign cfg_ready = 1'b1;
    // the result register must be free (or draining) to finish a command
    assign exec_go   = (state_reg == STATE_EXEC) && (!m_tvalid_reg || m_tready);

    assign usable_n    = (item_count_reg > DEPTH_N) ? DEPTH_N : item_count_reg;
    assign size_raised = (block_bytes_reg < SIZE_W'(WORD_BYTES)) ? SIZE_W'(WORD_BYTES)
                                                                  : block_bytes_reg;
    assign stride      = ({1'b0, size_raised} + WORD_MASK) & ~WORD_MASK;

    // read of the link below the current top is issued at accept; the free
    // stack only changes in the execute cycle, so the read never goes stale
    fbpa_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (in_fire),
        .raddr (stack_top_reg),
        .rdata (link_rdata)
    );

    // execute: pop / fresh / push decision
    always_comb begin
        stack_top_next      = stack_top_reg;
        stack_nonempty_next = stack_nonempty_reg;
        fresh_count_next    = fresh_count_reg;
        status              = STATUS_OK;
        slot_sel            = '0;
        link_we             = 1'b0;
        link_waddr          = req_reg[AW-1:0];
        link_wdata          = {stack_nonempty_reg, stack_top_reg};

        if (cmd_reg == CMD_ALLOC) begin
            if (stack_nonempty_reg) begin
                slot_sel            = SLOT_W'(stack_top_reg);
                stack_top_next      = link_rdata[AW-1:0];
                stack_nonempty_next = link_rdata[AW];
            end else if (fresh_count_reg < usable_n) begin
                slot_sel         = SLOT_W'(fresh_count_reg[AW-1:0]);
                fresh_count_next = fresh_count_reg + COUNT_W'(1);
            end else begin
                status = STATUS_EMPTY;
            end
        end else begin
            if ({1'b0, req_reg} < usable_n) begin
                slot_sel            = req_reg;
                link_we             = exec_go;
                stack_top_next      = req_reg[AW-1:0];
                stack_nonempty_next = 1'b1;
            end else begin
                status = STATUS_RANGE;
            end
        end
    end

    // slot * stride, then base add; zero slot on error gives offset zero
    assign offset  = {14'b0, slot_sel} * {8'b0, stride};
    assign address = (status == STATUS_OK) ? (base_address_reg + {10'b0, offset}) : '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            STATE_IDLE: begin
                if (in_fire) begin
                    state_next = STATE_EXEC;
                end
            end
            STATE_EXEC: begin
                if (exec_go) begin
                    state_next = STATE_IDLE;
                end
            end
            default: state_next = STATE_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (exec_go) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {address, slot_sel};
            m_tuser_next  = status;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= STATE_IDLE;
            stack_top_reg      <= '0;
            stack_nonempty_reg <= 1'b0;
            fresh_count_reg    <= '0;
            m_tvalid_reg       <= 1'b0;
            base_address_reg   <= '0;
            block_bytes_reg    <= BLOCK_BYTES_RST;
            item_count_reg     <= ITEM_COUNT_RST;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (exec_go) begin
                stack_top_reg      <= stack_top_next;
                stack_nonempty_reg <= stack_nonempty_next;
                fresh_count_reg    <= fresh_count_next;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BASE_ADDRESS: base_address_reg <= cfg_data[ADDR_W-1:0];
                    REG_BLOCK_BYTES:  block_bytes_reg  <= cfg_data[SIZE_W-1:0];
                    REG_ITEM_COUNT:   item_count_reg   <= cfg_data[COUNT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (in_fire) begin
            cmd_reg <= cmd_t'(s_tuser);
            req_reg <= s_tdata;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `FBPA_ASSERT_NOW(a_fresh_bound, aclk, aresetn, 1'b1, fresh_count_reg <= DEPTH_N)
    `FBPA_ASSERT_NEXT(a_accept_exec, aclk, aresetn, in_fire, state_reg == STATE_EXEC)
    `FBPA_ASSERT_NEXT(a_exec_result, aclk, aresetn, exec_go, m_tvalid_reg)
    `FBPA_ASSERT_NOW(a_error_zero, aclk, aresetn,
        m_tvalid_reg && (m_tuser_reg != STATUS_OK), m_tdata_reg == '0)
    `FBPA_ASSERT_NEXT(a_push_nonempty, aclk, aresetn,
        exec_go && (cmd_reg == CMD_FREE) && (status == STATUS_OK), stack_nonempty_reg)

endmodule
